### sv/nfida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfida_pkg: shared types and constants of the next-fit id allocator
// Field widths, status codes, controller states and the command/status
// structures that join the controller to the datapath.
// ---------------------------------------------------------------------------
package nfida_pkg;

    localparam int NUM_IDS_DEF   = 2048;
    localparam int WORD_BITS_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int RID_W   = 12;
    localparam int GRANT_W = 11;
    localparam int STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_ID    = 2'd2
    } t_status;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REL_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;      // capture the request, arm the scan
        logic rd_scan;   // read the next bitmap word of the scan
        logic chk;       // the word read last is being examined
        logic grant;     // mark the free id found, result = granted id
        logic no_free;   // result = exhausted
        logic bad_id;    // result = release id out of range
        logic rd_rel;    // read the word that holds the release id
        logic wr_rel;    // clear the release id's bit, result = ok
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic op_rel;     // request is a release
        logic rid_bad;    // release id is out of range
        logic found;      // the examined word holds a free id
        logic scan_done;  // every word of the scan has been read
    } t_dp_sts;

endpackage
`default_nettype wire

### sv/nfida_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfida_if: request and response channels of the id allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface nfida_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [nfida_pkg::RID_W-1:0] release_id;

    modport source (output valid, output op, output release_id, input ready);
    modport sink   (input valid, input op, input release_id, output ready);
endinterface

interface nfida_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nfida_pkg::GRANT_W-1:0] granted_id;
    logic [nfida_pkg::STAT_W-1:0]  status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface
`default_nettype wire

### sv/nfida_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfida_dp: bitmap memory, next-fit scan datapath and result register
// One bitmap word is read per cycle; the word read last is examined for a
// free id while the next read is issued.
// ---------------------------------------------------------------------------
module nfida_dp #(
    parameter int NUM_IDS   = nfida_pkg::NUM_IDS_DEF,
    parameter int WORD_BITS = nfida_pkg::WORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire nfida_pkg::t_dp_cmd            i_cmd,
    input  wire logic                          i_op,
    input  wire logic [nfida_pkg::RID_W-1:0]   i_release_id,
    output nfida_pkg::t_dp_sts                 o_sts,
    output logic      [nfida_pkg::GRANT_W-1:0] o_granted_id,
    output logic      [nfida_pkg::STAT_W-1:0]  o_status
);

    // WORD_BITS is a power of two, so an id splits into {word, bit}.
    localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int ID_W      = $clog2(NUM_IDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LEFT_W    = $clog2(NUM_WORDS + 2);
    localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(NUM_WORDS - 1);
    localparam logic [ID_W-1:0]   LAST_ID   = ID_W'(NUM_IDS - 1);
    localparam logic [LEFT_W-1:0] SCAN_LEN  = LEFT_W'(NUM_WORDS + 1);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_v;

    logic [ID_W-1:0]                r_start;
    logic                           r_op;
    logic [nfida_pkg::RID_W-1:0]    r_rid;
    logic [WA_W-1:0]                r_addr;
    logic [LEFT_W-1:0]              r_left;
    logic                           r_first;
    logic [WA_W-1:0]                r_raddr;
    logic [WORD_BITS-1:0]           r_rdata;
    logic                           r_rrow_v;
    logic [ID_W-1:0]                r_res_id;
    logic [nfida_pkg::STAT_W-1:0]   r_res_st;
    logic [nfida_pkg::GRANT_W-1:0]  r_out_id;
    logic [nfida_pkg::STAT_W-1:0]   r_out_st;

    logic                 rd_en;
    logic [WA_W-1:0]      rd_addr;
    logic [WA_W-1:0]      rid_word;
    logic [BIT_W-1:0]     rid_bit;
    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] start_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     free_idx;
    logic [ID_W-1:0]      found_id;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rid_bad;

    assign rid_word = WA_W'(r_rid >> BIT_W);
    assign rid_bit  = r_rid[BIT_W-1:0];
    assign rid_bad  = (32'(r_rid) >= NUM_IDS);

    assign rd_en   = i_cmd.rd_scan | i_cmd.rd_rel;
    assign rd_addr = i_cmd.rd_rel ? rid_word : r_addr;

    // A row never written since reset reads as all free.
    assign word_cur   = r_rrow_v ? r_rdata : '0;
    assign lim_mask   = (r_raddr == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
    assign start_mask = r_first ? ({WORD_BITS{1'b1}} << r_start[BIT_W-1:0])
                                : {WORD_BITS{1'b1}};
    assign free_bits  = ~word_cur & lim_mask & start_mask;

    // Lowest free bit of the examined word.
    always_comb begin
        free_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = BIT_W'(i);
            end
        end
    end

    assign found_id = ID_W'({r_raddr, free_idx});

    assign wr_en   = i_cmd.grant | i_cmd.wr_rel;
    assign wr_data = i_cmd.grant
                   ? (word_cur |  ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx))
                   : (word_cur & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << rid_bit));

    always_comb begin
        o_sts.op_rel    = (r_op == nfida_pkg::OP_RELEASE);
        o_sts.rid_bad   = rid_bad;
        o_sts.found     = |free_bits;
        o_sts.scan_done = (r_left == '0);
    end

    // Bitmap memory: one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_raddr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_v  <= '0;
            r_start  <= '0;
            r_rrow_v <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rrow_v <= r_row_v[rd_addr];
            end
            if (wr_en) begin
                r_row_v[r_raddr] <= 1'b1;
            end
            if (i_cmd.grant) begin
                r_start <= (found_id == LAST_ID) ? '0 : found_id + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_rid   <= i_release_id;
            r_addr  <= WA_W'(r_start >> BIT_W);
            r_left  <= SCAN_LEN;
            r_first <= 1'b1;
        end
        if (i_cmd.rd_scan) begin
            r_addr <= (r_addr == LAST_WORD) ? '0 : r_addr + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.chk) begin
            r_first <= 1'b0;
        end
        if (rd_en) begin
            r_raddr <= rd_addr;
        end
        if (i_cmd.grant) begin
            r_res_id <= found_id;
            r_res_st <= nfida_pkg::ST_OK;
        end
        if (i_cmd.no_free) begin
            r_res_id <= '0;
            r_res_st <= nfida_pkg::ST_EXHAUSTED;
        end
        if (i_cmd.bad_id) begin
            r_res_id <= '0;
            r_res_st <= nfida_pkg::ST_BAD_ID;
        end
        if (i_cmd.wr_rel) begin
            r_res_id <= '0;
            r_res_st <= nfida_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_id <= nfida_pkg::GRANT_W'(r_res_id);
            r_out_st <= r_res_st;
        end
    end

    assign o_granted_id = r_out_id;
    assign o_status     = r_out_st;

endmodule
`default_nettype wire

### sv/nfida_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nfida_ctrl: request sequencer of the id allocator
// Steps the datapath through decode, scan or release, and hands the result
// to the output register.
// ---------------------------------------------------------------------------
module nfida_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    input  wire nfida_pkg::t_dp_sts i_sts,
    output nfida_pkg::t_dp_cmd      o_cmd
);

    nfida_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfida_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            nfida_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = nfida_pkg::S_DECODE;
                end
            end
            nfida_pkg::S_DECODE: begin
                if (!i_sts.op_rel) begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = nfida_pkg::S_SCAN;
                end else if (i_sts.rid_bad) begin
                    o_cmd.bad_id = 1'b1;
                    n_state      = nfida_pkg::S_FINISH;
                end else begin
                    o_cmd.rd_rel = 1'b1;
                    n_state      = nfida_pkg::S_REL_WR;
                end
            end
            nfida_pkg::S_SCAN: begin
                o_cmd.chk = 1'b1;
                if (i_sts.found) begin
                    o_cmd.grant = 1'b1;
                    n_state     = nfida_pkg::S_FINISH;
                end else if (i_sts.scan_done) begin
                    o_cmd.no_free = 1'b1;
                    n_state       = nfida_pkg::S_FINISH;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                end
            end
            nfida_pkg::S_REL_WR: begin
                o_cmd.wr_rel = 1'b1;
                n_state      = nfida_pkg::S_FINISH;
            end
            nfida_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = nfida_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfida_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### sv/next_fit_id_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// next_fit_id_bitmap_allocator: next-fit identifier allocator over a bitmap
// Hands out and takes back ids 0..NUM_IDS-1 kept as a bitmap in memory.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transfer: op selects allocate or release,
//   release_id names the id to free on a release. o_rsp returns exactly one
//   result per request, in order: granted_id and status (ok, no free id, or
//   release id out of range).
//   An allocate scans the bitmap one word per cycle through the single read
//   port of the bitmap memory, starting at the word that holds the id after
//   the last grant and wrapping to id 0; at most NUM_IDS/WORD_BITS + 1 words
//   are examined. An allocate steps from decode through the scan to the
//   finish state. A release is a read-modify-write of one word, read in
//   decode and written back in its own state; an out-of-range release goes
//   from decode straight to finish. One request is in flight at a time, so
//   a new request is taken only once the last one has left its finish state.
//   The output register decouples the two sides: the next request is taken
//   while a result still waits for its transfer, and a finished request
//   holds in its last state until the output register frees up.
//   Reset clears the whole bitmap at once (per-word valid flags) and sets
//   the search start to id 0; a request may follow reset directly.
// ---------------------------------------------------------------------------
module next_fit_id_bitmap_allocator #(
    parameter int NUM_IDS   = nfida_pkg::NUM_IDS_DEF,
    parameter int WORD_BITS = nfida_pkg::WORD_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nfida_req_if.sink  i_req,
    nfida_rsp_if.source o_rsp
);

    nfida_pkg::t_dp_cmd cmd;
    nfida_pkg::t_dp_sts sts;

    // Sequencer: request/response handshakes and command sequence.
    nfida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: bitmap memory, scan logic, search start and result register.
    nfida_dp #(
        .NUM_IDS   (NUM_IDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_req.op),
        .i_release_id (i_req.release_id),
        .o_sts        (sts),
        .o_granted_id (o_rsp.granted_id),
        .o_status     (o_rsp.status)
    );

endmodule
`default_nettype wire
